[sv/mapped_keyboard_display_bus_macros.svh]
// Assertion macros for the checker file of the keyboard/display bus.
// Each macro expects signals named aclk and aresetn in the scope that uses it.
`ifndef MAPPED_KEYBOARD_DISPLAY_BUS_MACROS_SVH
`define MAPPED_KEYBOARD_DISPLAY_BUS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MKDB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MKDB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/mkdb_pkg.sv]
// Types and constants for the memory-mapped keyboard/display bus.
// Used by the top level and by its checker; depends on nothing else.
`default_nettype none

package mkdb_pkg;

    // Kind of an input transaction, carried in s_tuser.
    typedef enum logic [1:0] {
        CMD_KEY      = 2'd0,
        CMD_READ     = 2'd1,
        CMD_WRITE    = 2'd2,
        CMD_ROM_LOAD = 2'd3
    } cmd_t;

    localparam int AddrWidth     = 16;
    localparam int ByteWidth     = 8;
    localparam int CharWidth     = 7;
    localparam int InDataWidth   = 24;
    localparam int OutDataWidth  = 16;

    localparam logic [AddrWidth-1:0] KEY_DATA_ADDR  = 16'hD010;
    localparam logic [AddrWidth-1:0] KEY_STAT_ADDR  = 16'hD011;
    localparam logic [AddrWidth-1:0] DISP_DATA_ADDR = 16'hD012;
    localparam logic [AddrWidth-1:0] DISP_CTRL_ADDR = 16'hD013;
    localparam logic [AddrWidth-1:0] ROM_BASE_RESET = 16'hFF00;

    localparam logic [ByteWidth-1:0] CHAR_CR    = 8'h0D;
    localparam logic [ByteWidth-1:0] CHAR_LF    = 8'h0A;
    localparam logic [ByteWidth-1:0] LOWER_A    = 8'h61;
    localparam logic [ByteWidth-1:0] LOWER_Z    = 8'h7A;
    localparam logic [ByteWidth-1:0] CASE_DELTA = 8'h20;

endpackage

`default_nettype wire

[sv/mapped_keyboard_display_bus.sv]
// Memory bus with a keyboard and a display mapped into its address space.
// Depends on mkdb_pkg; the main store is a single-port synchronous memory.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_tvalid/s_tready  tdata {data, address}, tuser cmd
//   m_        out        m_tvalid/m_tready  tdata {display_char, read_data}, tuser display_valid
//   cfg_      in         cfg_wr_en          cfg_wr_data = rom_base
//
// An item passes three steps: accept, store access, result capture; the
// next item is accepted as soon as the previous result is in the output
// register, even if it is not taken. After reset the store is cleared one
// entry per cycle, all STORE_DEPTH entries, with s_tready low. A stalled
// result holds in the output register.
`default_nettype none

module mapped_keyboard_display_bus #(
    parameter int STORE_DEPTH = 65536
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [mkdb_pkg::InDataWidth-1:0]   s_tdata,   // address[15:0], data[23:16]
    input  wire logic [1:0]                         s_tuser,   // cmd[1:0]
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [mkdb_pkg::OutDataWidth-1:0]       m_tdata,   // read_data[7:0], display_char[14:8]
    output logic [0:0]                              m_tuser,   // display_valid[0]
    input  wire logic                               cfg_wr_en,
    input  wire logic [mkdb_pkg::AddrWidth-1:0]     cfg_wr_data
);

    localparam int IdxWidth  = $clog2(STORE_DEPTH);
    // Number of compare-subtract steps that fold a 16-bit address into the store.
    localparam int WrapSteps = $clog2((65536 + STORE_DEPTH - 1) / STORE_DEPTH);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_DONE
    } state_t;

    state_t                               state_reg;
    logic [IdxWidth-1:0]                  clr_cnt_reg;
    mkdb_pkg::cmd_t                       cmd_reg;
    logic [mkdb_pkg::AddrWidth-1:0]       addr_reg;
    logic [mkdb_pkg::ByteWidth-1:0]       data_reg;
    logic [mkdb_pkg::AddrWidth-1:0]       rom_base_reg;
    logic [mkdb_pkg::ByteWidth-1:0]       key_byte_reg;
    logic                                 key_ready_reg;
    logic [mkdb_pkg::ByteWidth-1:0]       prev_key_reg;
    logic                                 sel_mem_reg;
    logic [mkdb_pkg::ByteWidth-1:0]       io_rd_reg;
    logic                                 disp_valid_reg;
    logic [mkdb_pkg::CharWidth-1:0]       disp_char_reg;
    logic                                 out_valid_reg;
    logic [mkdb_pkg::ByteWidth-1:0]       out_rd_reg;
    logic                                 out_dv_reg;
    logic [mkdb_pkg::CharWidth-1:0]       out_dc_reg;

    logic [mkdb_pkg::ByteWidth-1:0]       mem [STORE_DEPTH];
    logic [mkdb_pkg::ByteWidth-1:0]       mem_q_reg;

    logic [IdxWidth-1:0]                  store_idx;
    logic [IdxWidth-1:0]                  mem_addr;
    logic                                 mem_we;
    logic                                 mem_re;
    logic [mkdb_pkg::ByteWidth-1:0]       mem_wdata;
    logic                                 is_io;
    logic                                 key_repeat;
    logic [mkdb_pkg::ByteWidth-1:0]       key_folded;
    logic                                 out_free;

    // Fold the bus address into the store by conditional subtraction of
    // STORE_DEPTH times a power of two, largest first.
    always_comb begin
        logic [17:0] rem;
        rem = {2'b00, addr_reg};
        for (int k = WrapSteps - 1; k >= 0; k--) begin
            if (rem >= 18'(STORE_DEPTH << k)) begin
                rem = rem - 18'(STORE_DEPTH << k);
            end
        end
        store_idx = rem[IdxWidth-1:0];
    end

    assign is_io = (addr_reg == mkdb_pkg::KEY_DATA_ADDR) || (addr_reg == mkdb_pkg::KEY_STAT_ADDR)
                || (addr_reg == mkdb_pkg::DISP_DATA_ADDR) || (addr_reg == mkdb_pkg::DISP_CTRL_ADDR);

    // A CR after a CR, or an LF after an LF, is dropped without a trace.
    assign key_repeat = (data_reg == prev_key_reg)
                     && ((data_reg == mkdb_pkg::CHAR_CR) || (data_reg == mkdb_pkg::CHAR_LF));

    always_comb begin
        key_folded = data_reg;
        if (data_reg >= mkdb_pkg::LOWER_A && data_reg <= mkdb_pkg::LOWER_Z) begin
            key_folded = data_reg - mkdb_pkg::CASE_DELTA;
        end
        if (data_reg == mkdb_pkg::CHAR_LF) begin
            key_folded = mkdb_pkg::CHAR_CR;
        end
    end

    always_comb begin
        mem_addr  = store_idx;
        mem_wdata = data_reg;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        if (state_reg == S_CLEAR) begin
            mem_addr  = clr_cnt_reg;
            mem_wdata = '0;
            mem_we    = 1'b1;
        end else if (state_reg == S_EXEC) begin
            mem_we = (cmd_reg == mkdb_pkg::CMD_ROM_LOAD)
                  || ((cmd_reg == mkdb_pkg::CMD_WRITE) && !is_io && (addr_reg < rom_base_reg));
            mem_re = (cmd_reg == mkdb_pkg::CMD_READ) && !is_io;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q_reg <= mem[mem_addr];
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            rom_base_reg  <= mkdb_pkg::ROM_BASE_RESET;
            key_byte_reg  <= '0;
            key_ready_reg <= 1'b0;
            prev_key_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                rom_base_reg <= cfg_wr_data;
            end
            // In S_DONE the output register is refilled below instead.
            if (out_valid_reg && m_tready && (state_reg != S_DONE)) begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == IdxWidth'(STORE_DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg   <= mkdb_pkg::cmd_t'(s_tuser[1:0]);
                        addr_reg  <= s_tdata[15:0];
                        data_reg  <= s_tdata[23:16];
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    sel_mem_reg    <= mem_re;
                    io_rd_reg      <= '0;
                    disp_valid_reg <= 1'b0;
                    disp_char_reg  <= '0;
                    unique case (cmd_reg)
                        mkdb_pkg::CMD_KEY: begin
                            if (!key_repeat) begin
                                prev_key_reg  <= data_reg;
                                key_byte_reg  <= key_folded;
                                key_ready_reg <= 1'b1;
                            end
                        end
                        mkdb_pkg::CMD_READ: begin
                            if (addr_reg == mkdb_pkg::KEY_DATA_ADDR) begin
                                io_rd_reg     <= key_byte_reg | {key_ready_reg, 7'b0};
                                key_ready_reg <= 1'b0;
                            end else if (addr_reg == mkdb_pkg::KEY_STAT_ADDR) begin
                                io_rd_reg <= {key_ready_reg, 7'b0};
                            end
                        end
                        mkdb_pkg::CMD_WRITE: begin
                            if (addr_reg == mkdb_pkg::DISP_DATA_ADDR) begin
                                disp_valid_reg <= 1'b1;
                                disp_char_reg  <= data_reg[mkdb_pkg::CharWidth-1:0];
                            end
                        end
                        mkdb_pkg::CMD_ROM_LOAD: begin
                            // The store write itself is issued combinationally.
                        end
                        default: begin
                        end
                    endcase
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_rd_reg    <= sel_mem_reg ? mem_q_reg : io_rd_reg;
                        out_dv_reg    <= disp_valid_reg;
                        out_dc_reg    <= disp_char_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_dc_reg, out_rd_reg};
    assign m_tuser  = out_dv_reg;

endmodule

`default_nettype wire

[sv/mkdb_checker.sv]
// Port-level checker for the keyboard/display bus, bound to the top level.
// Depends on mkdb_pkg and mapped_keyboard_display_bus_macros.svh.
`default_nettype none
`include "mapped_keyboard_display_bus_macros.svh"

module mkdb_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_tvalid,
    input wire logic                               s_tready,
    input wire logic [mkdb_pkg::InDataWidth-1:0]   s_tdata,
    input wire logic [1:0]                         s_tuser,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [mkdb_pkg::OutDataWidth-1:0]  m_tdata,
    input wire logic [0:0]                         m_tuser
);

    logic s_fire;
    logic disp_cmd;

    assign s_fire   = s_tvalid && s_tready;
    assign disp_cmd = (s_tuser == mkdb_pkg::CMD_WRITE) && (s_tdata[15:0] == mkdb_pkg::DISP_DATA_ADDR);

    // A stalled result transaction must hold its payload.
    `MKDB_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // Only one item is in flight, so an accept is never directly followed by another.
    `MKDB_ASSERT_NXT(a_one_in_flight, s_fire, !s_tready, "accepted two items back to back")

    // Without a display write the character field stays zero.
    `MKDB_ASSERT_IMP(a_char_zero, m_tvalid && !m_tuser[0], m_tdata[15:8] == 8'h00,
        "display character without display write")

    // A display write returns no read data.
    `MKDB_ASSERT_IMP(a_disp_no_read, m_tvalid && m_tuser[0], m_tdata[7:0] == 8'h00,
        "read data on a display write")

    // A display write is never answered within the next cycle.
    `MKDB_ASSERT_NXT(a_disp_latency, s_fire && disp_cmd, !(m_tvalid && m_tuser[0] && !$past(m_tvalid)),
        "display result too early")

endmodule

bind mapped_keyboard_display_bus mkdb_checker u_mkdb_checker (.*);

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the keyboard/display memory bus.
// Depends on mkdb_pkg and mapped_keyboard_display_bus; a scoreboard class keeps
// its own copy of the store and keyboard latch and checks every result in order.
`default_nettype none

module tb_top;

    localparam int STORE_SIZE  = 65536;
    // Nothing moves while the store is cleared after reset, so the limit
    // sits well above that pass.
    localparam int IDLE_LIMIT  = 4 * STORE_SIZE;
    localparam int HOLD_CYCLES = 120;
    localparam int PHASE_ITEMS = 185;
    localparam int NUM_PHASES  = 7;

    typedef struct {
        logic [mkdb_pkg::ByteWidth-1:0] read_data;
        logic                           display_valid;
        logic [mkdb_pkg::CharWidth-1:0] display_char;
    } bus_result_t;

    class bus_scoreboard;
        logic [mkdb_pkg::ByteWidth-1:0] mem_image [0:STORE_SIZE-1];
        logic [mkdb_pkg::ByteWidth-1:0] key_byte;
        logic                           key_ready;
        logic [mkdb_pkg::ByteWidth-1:0] last_raw_key;
        logic [mkdb_pkg::AddrWidth-1:0] rom_base;
        bus_result_t                    expected_q [$];
        int                             errors;
        int                             checked;

        function new();
            foreach (mem_image[i]) mem_image[i] = '0;
            key_byte     = '0;
            key_ready    = 1'b0;
            last_raw_key = '0;
            rom_base     = mkdb_pkg::ROM_BASE_RESET;
            errors       = 0;
            checked      = 0;
        endfunction

        function void set_rom_base(logic [mkdb_pkg::AddrWidth-1:0] value);
            rom_base = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Works out the result of one accepted transaction and updates the state.
        function void note_item(mkdb_pkg::cmd_t cmd, logic [mkdb_pkg::AddrWidth-1:0] addr,
                                logic [mkdb_pkg::ByteWidth-1:0] data);
            bus_result_t                    res;
            logic [mkdb_pkg::ByteWidth-1:0] k;
            res = '{read_data: '0, display_valid: 1'b0, display_char: '0};
            case (cmd)
                mkdb_pkg::CMD_KEY: begin
                    k = data;
                    // A line end that repeats the previous raw key is dropped.
                    if (!(k == last_raw_key &&
                          (k == mkdb_pkg::CHAR_CR || k == mkdb_pkg::CHAR_LF))) begin
                        last_raw_key = k;
                        if (k >= mkdb_pkg::LOWER_A && k <= mkdb_pkg::LOWER_Z)
                            k = k - mkdb_pkg::CASE_DELTA;
                        if (k == mkdb_pkg::CHAR_LF) k = mkdb_pkg::CHAR_CR;
                        key_byte  = k;
                        key_ready = 1'b1;
                    end
                end
                mkdb_pkg::CMD_READ: begin
                    if (addr == mkdb_pkg::KEY_DATA_ADDR) begin
                        res.read_data = key_byte | {key_ready, 7'b0};
                        key_ready     = 1'b0;
                    end else if (addr == mkdb_pkg::KEY_STAT_ADDR) begin
                        res.read_data = {key_ready, 7'b0};
                    end else if (addr == mkdb_pkg::DISP_DATA_ADDR ||
                                 addr == mkdb_pkg::DISP_CTRL_ADDR) begin
                        res.read_data = '0;
                    end else begin
                        res.read_data = mem_image[addr];
                    end
                end
                mkdb_pkg::CMD_WRITE: begin
                    if (addr == mkdb_pkg::DISP_DATA_ADDR) begin
                        res.display_valid = 1'b1;
                        res.display_char  = data[mkdb_pkg::CharWidth-1:0];
                    end else if (addr != mkdb_pkg::DISP_CTRL_ADDR &&
                                 addr != mkdb_pkg::KEY_DATA_ADDR &&
                                 addr != mkdb_pkg::KEY_STAT_ADDR && addr < rom_base) begin
                        mem_image[addr] = data;
                    end
                end
                default: begin
                    mem_image[addr] = data;
                end
            endcase
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [mkdb_pkg::ByteWidth-1:0] rd, logic dv,
                                   logic [mkdb_pkg::CharWidth-1:0] dc);
            bus_result_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, read_data %02h display_valid %0d display_char %02h",
                         $time, rd, dv, dc);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (rd !== want.read_data) begin
                $display("%0t: read_data mismatch, expected %02h, actual %02h",
                         $time, want.read_data, rd);
                errors++;
            end
            if (dv !== want.display_valid) begin
                $display("%0t: display_valid mismatch, expected %0d, actual %0d",
                         $time, want.display_valid, dv);
                errors++;
            end
            if (dc !== want.display_char) begin
                $display("%0t: display_char mismatch, expected %02h, actual %02h",
                         $time, want.display_char, dc);
                errors++;
            end
        endfunction
    endclass

    logic                              aclk        = 1'b0;
    logic                              aresetn     = 1'b0;
    logic                              s_tvalid    = 1'b0;
    logic                              s_tready;
    logic [mkdb_pkg::InDataWidth-1:0]  s_tdata     = '0;  // address[15:0], data[23:16]
    logic [1:0]                        s_tuser     = '0;  // cmd[1:0]
    logic                              m_tvalid;
    logic                              m_tready    = 1'b0;
    logic [mkdb_pkg::OutDataWidth-1:0] m_tdata;           // read_data[7:0], display_char[14:8]
    logic [0:0]                        m_tuser;           // display_valid[0]
    logic                              cfg_wr_en   = 1'b0;
    logic [mkdb_pkg::AddrWidth-1:0]    cfg_wr_data = '0;

    bus_scoreboard                  sb;
    logic [mkdb_pkg::AddrWidth-1:0] cur_rom_base = mkdb_pkg::ROM_BASE_RESET;
    logic [mkdb_pkg::AddrWidth-1:0] rom_settings [NUM_PHASES];
    int                             items_sent    = 0;
    int                             burst_left    = 0;
    int                             max_gap       = 0;
    int                             hold_requests = 0;
    int                             hold_served   = 0;
    int                             hold_left     = 0;
    int                             rx_cycle      = 0;
    int                             rx_style      = 0;
    int                             idle_cycles   = 0;

    mapped_keyboard_display_bus #(
        .STORE_DEPTH(STORE_SIZE)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Receiver: switches among four stall styles at random, and serves long
    // hold-off requests from the stimulus process.
    always @(posedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 200 == 0) rx_style = $urandom_range(0, 3);
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            case (rx_style)
                0:       m_tready <= 1'b1;
                1:       m_tready <= $urandom_range(0, 1);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= rx_cycle[2];
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[mkdb_pkg::ByteWidth-1:0], m_tuser[0], m_tdata[14:8]);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Offers one transaction and returns at the edge where it is accepted.
    task automatic send_item(input mkdb_pkg::cmd_t cmd,
                             input logic [mkdb_pkg::AddrWidth-1:0] addr,
                             input logic [mkdb_pkg::ByteWidth-1:0] data);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {data, addr};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(cmd, addr, data);
        items_sent++;
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0 && max_gap > 0) begin
            gap = $urandom_range(1, max_gap);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_rom_base(input logic [mkdb_pkg::AddrWidth-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_rom_base(value);
        cur_rom_base = value;
    endtask

    // Addresses cluster on the I/O registers, the edges of the protected
    // region and two small windows, so that reads hit written cells.
    function automatic logic [mkdb_pkg::AddrWidth-1:0] pick_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return mkdb_pkg::KEY_DATA_ADDR + 16'($urandom_range(0, 3));
        if (r < 45) return 16'($urandom_range(0, 15));
        if (r < 60) return cur_rom_base - 16'd2 + 16'($urandom_range(0, 3));
        if (r < 75) return 16'hFFF0 + 16'($urandom_range(0, 15));
        if (r < 80) return 16'hD00C + 16'($urandom_range(0, 7));
        return 16'($urandom);
    endfunction

    function automatic logic [mkdb_pkg::ByteWidth-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return mkdb_pkg::CHAR_CR;
        if (r < 35) return mkdb_pkg::CHAR_LF;
        if (r < 65) return 8'($urandom_range(mkdb_pkg::LOWER_A, mkdb_pkg::LOWER_Z));
        return 8'($urandom);
    endfunction

    function automatic mkdb_pkg::cmd_t pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return mkdb_pkg::CMD_KEY;
        if (r < 60) return mkdb_pkg::CMD_READ;
        if (r < 88) return mkdb_pkg::CMD_WRITE;
        return mkdb_pkg::CMD_ROM_LOAD;
    endfunction

    task automatic run_random(input int count);
        int                             n;
        int                             r;
        mkdb_pkg::cmd_t                 cmd;
        logic [mkdb_pkg::AddrWidth-1:0] addr;
        n = 0;
        while (n < count) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                // Key press followed by the usual status and data polls.
                send_item(mkdb_pkg::CMD_KEY, 16'($urandom), pick_key());
                pace();
                send_item(mkdb_pkg::CMD_READ, mkdb_pkg::KEY_STAT_ADDR, 8'($urandom));
                pace();
                send_item(mkdb_pkg::CMD_READ, mkdb_pkg::KEY_DATA_ADDR, 8'($urandom));
                pace();
                n += 3;
            end else if (r < 30) begin
                addr = pick_addr();
                send_item(($urandom_range(0, 3) == 0) ? mkdb_pkg::CMD_ROM_LOAD
                                                      : mkdb_pkg::CMD_WRITE,
                          addr, 8'($urandom));
                pace();
                send_item(mkdb_pkg::CMD_READ, addr, 8'($urandom));
                pace();
                n += 2;
            end else begin
                cmd = pick_cmd();
                send_item(cmd, pick_addr(),
                          (cmd == mkdb_pkg::CMD_KEY) ? pick_key() : 8'($urandom));
                pace();
                n++;
            end
        end
    endtask

    // Runs with rom_base at its reset value.
    task automatic run_directed();
        send_item(mkdb_pkg::CMD_READ,     mkdb_pkg::KEY_DATA_ADDR,  8'h00);
        send_item(mkdb_pkg::CMD_READ,     mkdb_pkg::KEY_STAT_ADDR,  8'hFF);
        send_item(mkdb_pkg::CMD_KEY,      16'hFFFF,                 mkdb_pkg::LOWER_A);
        send_item(mkdb_pkg::CMD_READ,     mkdb_pkg::KEY_STAT_ADDR,  8'h00);
        send_item(mkdb_pkg::CMD_READ,     mkdb_pkg::KEY_DATA_ADDR,  8'h00);
        send_item(mkdb_pkg::CMD_READ,     mkdb_pkg::KEY_DATA_ADDR,  8'h00);
        send_item(mkdb_pkg::CMD_KEY,      16'h0000,                 mkdb_pkg::CHAR_LF);
        send_item(mkdb_pkg::CMD_KEY,      16'h0000,                 mkdb_pkg::CHAR_LF);
        send_item(mkdb_pkg::CMD_KEY,      16'h0000,                 mkdb_pkg::CHAR_CR);
        send_item(mkdb_pkg::CMD_KEY,      16'h0000,                 mkdb_pkg::CHAR_CR);
        send_item(mkdb_pkg::CMD_READ,     mkdb_pkg::KEY_DATA_ADDR,  8'h00);
        send_item(mkdb_pkg::CMD_KEY,      16'h0000,                 mkdb_pkg::LOWER_Z);
        send_item(mkdb_pkg::CMD_KEY,      16'h0000,                 8'h60);
        send_item(mkdb_pkg::CMD_KEY,      16'h0000,                 8'h7B);
        send_item(mkdb_pkg::CMD_KEY,      16'h0000,                 8'hFF);
        send_item(mkdb_pkg::CMD_READ,     mkdb_pkg::KEY_DATA_ADDR,  8'h00);
        send_item(mkdb_pkg::CMD_WRITE,    mkdb_pkg::DISP_DATA_ADDR, 8'hFF);
        send_item(mkdb_pkg::CMD_WRITE,    mkdb_pkg::DISP_DATA_ADDR, 8'h00);
        send_item(mkdb_pkg::CMD_WRITE,    mkdb_pkg::KEY_DATA_ADDR,  8'h55);
        send_item(mkdb_pkg::CMD_WRITE,    mkdb_pkg::DISP_CTRL_ADDR, 8'hAA);
        send_item(mkdb_pkg::CMD_READ,     mkdb_pkg::DISP_CTRL_ADDR, 8'h00);
        send_item(mkdb_pkg::CMD_WRITE,    16'h0000,                 8'hFF);
        send_item(mkdb_pkg::CMD_READ,     16'h0000,                 8'h00);
        send_item(mkdb_pkg::CMD_WRITE,    16'hFEFF,                 8'h5A);
        send_item(mkdb_pkg::CMD_WRITE,    mkdb_pkg::ROM_BASE_RESET, 8'h33);
        send_item(mkdb_pkg::CMD_READ,     mkdb_pkg::ROM_BASE_RESET, 8'h00);
        send_item(mkdb_pkg::CMD_ROM_LOAD, 16'hFFFF,                 8'hA5);
        send_item(mkdb_pkg::CMD_READ,     16'hFFFF,                 8'h00);
        send_item(mkdb_pkg::CMD_ROM_LOAD, mkdb_pkg::DISP_DATA_ADDR, 8'h77);
        send_item(mkdb_pkg::CMD_READ,     mkdb_pkg::DISP_DATA_ADDR, 8'h00);
    endtask

    initial begin
        int saved_gap;
        sb = new();
        rom_settings = '{mkdb_pkg::ROM_BASE_RESET, 16'h0000, 16'hFFFF, 16'h8000,
                         16'($urandom), mkdb_pkg::DISP_DATA_ADDR, 16'h0008};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_results();
            write_rom_base(rom_settings[p]);
            if (p == 0) run_directed();
            max_gap    = (p == 3) ? 0 : $urandom_range(2, 8);
            burst_left = $urandom_range(1, 24);
            if (p == 1) begin
                // Long output stall while the input keeps offering back to back.
                hold_requests++;
                saved_gap = max_gap;
                max_gap   = 0;
                run_random(40);
                max_gap   = saved_gap;
            end
            run_random(PHASE_ITEMS);
        end

        wait_results();
        repeat (8) @(posedge aclk);
        $display("Sent %0d transactions and checked %0d results across %0d rom_base settings,",
                 items_sent, sb.checked, NUM_PHASES);
        $display("with key polls, display writes, protected writes, ROM loads and a long stall.");
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
